@@ hw/rtl/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash values, round helper functions and the
// sequencer state type shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned Rounds     = 64;
	localparam logic [7:0]  PadByte    = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_UPDATE,
		ST_PAD,
		ST_EMIT
	} seq_state_t;

	// Control from the sequencer to the round datapath
	typedef struct packed {
		logic       init_hash;  // load the initial hash values
		logic       load_work;  // copy chaining words into the working set
		logic       do_round;   // run one round with the current schedule word
		logic       update;     // add working set into chaining words
		logic [5:0] round;      // round number
	} core_ctrl_t;

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		unique case (t)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] h;
		unique case (i)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
			default: h = '0;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

@@ hw/rtl/sha256_sched.sv @@
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word shift window. Takes block words during load, then produces
// one expanded schedule word per round.
// ----------------------------------------------------------------------------
module sha256_sched import sha256_pkg::*; (
	input  logic        clk,
	input  logic        load,       // shift in a block word
	input  logic [31:0] load_word,
	input  logic        advance,    // shift for one round
	output logic [31:0] w_cur       // schedule word for the current round
);

	logic [31:0] win_q [16];
	logic [31:0] s0, s1, w_new;

	// Expand the next word from the window
	always_comb begin
		s0    = ror(win_q[1], 7) ^ ror(win_q[1], 18) ^ (win_q[1] >> 3);
		s1    = ror(win_q[14], 17) ^ ror(win_q[14], 19) ^ (win_q[14] >> 10);
		w_new = win_q[0] + s0 + win_q[9] + s1;
	end

	assign w_cur = win_q[0];

	// Shift the window
	always_ff @(posedge clk) begin
		if (load || advance) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= load ? load_word : w_new;
		end
	end

endmodule

@@ hw/rtl/sha256_core.sv @@
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One shared round datapath over the eight working words, plus the
// chaining words it folds into at the end of each block.
// ----------------------------------------------------------------------------
module sha256_core import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  core_ctrl_t  ctrl,
	input  logic [31:0] w_cur,
	input  logic [2:0]  rd_index,
	output logic [31:0] rd_word
);

	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] big0, big1, choose, major, x1, x2;

	// One compression round
	always_comb begin
		big1   = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		x1     = v_q[7] + big1 + choose + round_k(ctrl.round) + w_cur;
		big0   = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		x2     = big0 + major;
	end

	assign rd_word = h_q[rd_index];

	// Chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else if (ctrl.init_hash) begin
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else if (ctrl.update) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
	end

	// Working words
	always_ff @(posedge clk) begin
		if (ctrl.load_work) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (ctrl.do_round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + x1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= x1 + x2;
		end
	end

endmodule

@@ hw/rtl/sha256_byte_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Gathers bytes into 32-bit block words, compresses each full block with a
// one-round-per-cycle unit, pads on end of message and streams the digest.
// ----------------------------------------------------------------------------
// A plain byte word is taken one per cycle; a word that completes a 64-byte
// block holds s_tready low while the block is loaded, run through the rounds
// and added into the chaining words by the single shared round unit. An
// end-of-message word adds one or two such compressions for the padding,
// each after a pass that writes the pad words into the block, and then eight
// digest words on the master side, one per accepted cycle, word 0 (most
// significant) first. The block words are held in a 16 x 32 register file
// written one word per four bytes; the block need not be cleared after reset.
module sha256_byte_stream_hasher import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] message_byte
	input  logic        s_tlast,   // end_of_message
	input  logic        s_tuser,   // byte_valid
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast    // last_word
);

	seq_state_t  state_q, state_d;
	logic [31:0] blk_q [16];      // block words
	logic [23:0] part_q;           // bytes of the word being gathered
	logic [5:0]  fill_q;           // bytes in block
	logic [63:0] bits_q;
	logic        fin_q;            // padding pending after this compression
	logic        padded_q;         // 0x80 already placed
	logic [5:0]  cnt_q;            // load / round / pad / emit counter
	logic        s_acc, m_acc;
	logic [5:0]  fill_n;
	logic [31:0] full_word, pad_word;
	logic        sched_load;
	logic [31:0] w_cur;
	logic [31:0] rd_word;
	core_ctrl_t  ctrl;

	assign s_acc  = s_tvalid && s_tready;
	assign m_acc  = m_tvalid && m_tready;
	assign fill_n = fill_q + 6'd1;
	assign full_word = {part_q, s_tdata};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (s_tuser && fill_q == 6'd63) state_d = ST_LOAD;
					else if (s_tlast)                state_d = ST_PAD;
				end
			end
			ST_LOAD:   if (cnt_q == 6'd15) state_d = ST_ROUND;
			ST_ROUND:  if (cnt_q == 6'd63) state_d = ST_UPDATE;
			ST_UPDATE: begin
				// pad while padding is pending, emit after the length block, or go back for bytes
				priority if (fin_q) state_d = ST_PAD;
				else if (padded_q)  state_d = ST_EMIT;
				else                state_d = ST_IDLE;
			end
			ST_PAD:    if (cnt_q == 6'd15) state_d = ST_LOAD;
			ST_EMIT:   if (m_acc && cnt_q == 6'd7) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready       = (state_q == ST_IDLE);
		m_tvalid       = (state_q == ST_EMIT);
		m_tdata        = rd_word;
		m_tuser        = cnt_q[2:0];
		m_tlast        = (cnt_q[2:0] == 3'd7);
		sched_load     = (state_q == ST_LOAD);
		ctrl.init_hash = (state_q == ST_EMIT) && m_acc && cnt_q == 6'd7;
		ctrl.load_work = (state_q == ST_LOAD) && cnt_q == 6'd15;
		ctrl.do_round  = (state_q == ST_ROUND);
		ctrl.update    = (state_q == ST_UPDATE);
		ctrl.round     = cnt_q;
	end

	// Padding word for slot cnt_q: 0x80 at fill position, length in last two
	always_comb begin
		pad_word = blk_q[cnt_q[3:0]];
		if (!padded_q && cnt_q[3:0] == fill_q[5:2]) begin
			unique case (fill_q[1:0])
				2'd0: pad_word = {PadByte, 24'h0};
				2'd1: pad_word = {part_q[7:0], PadByte, 16'h0};
				2'd2: pad_word = {part_q[15:0], PadByte, 8'h0};
				2'd3: pad_word = {part_q[23:0], PadByte};
				default: pad_word = '0;
			endcase
		end else if (!padded_q && cnt_q[3:0] < fill_q[5:2]) begin
			pad_word = blk_q[cnt_q[3:0]];
		end else begin
			pad_word = 32'h0;
		end
		if (fill_q < 6'd56 || padded_q) begin
			if (cnt_q[3:0] == 4'd14) pad_word = bits_q[63:32];
			if (cnt_q[3:0] == 4'd15) pad_word = bits_q[31:0];
		end
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			bits_q   <= '0;
			fin_q    <= 1'b0;
			padded_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) cnt_q <= '0;
			else if (state_q != ST_IDLE && (state_q != ST_EMIT || m_acc)) cnt_q <= cnt_q + 6'd1;
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						fin_q <= s_tlast;
						if (s_tuser) begin
							fill_q <= fill_n;
							bits_q <= bits_q + 64'd8;
						end
					end
				end
				ST_PAD: begin
					if (cnt_q == 6'd15) begin
						// second pass needed if length did not fit
						if (!padded_q && fill_q >= 6'd56) begin
							padded_q <= 1'b1;
						end else begin
							padded_q <= 1'b1;
							fin_q    <= 1'b0;
						end
					end
				end
				ST_EMIT: begin
					if (m_acc && cnt_q == 6'd7) begin
						fill_q   <= '0;
						bits_q   <= '0;
						padded_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Gather bytes into block words; pad pass rewrites the block
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser) begin
			part_q <= full_word[23:0];
			if (fill_q[1:0] == 2'd3) blk_q[fill_q[5:2]] <= full_word;
		end
		if (state_q == ST_PAD) blk_q[cnt_q[3:0]] <= pad_word;
	end

	sha256_sched u_sched (
		.clk       (clk),
		.load      (sched_load),
		.load_word (blk_q[cnt_q[3:0]]),
		.advance   (ctrl.do_round),
		.w_cur     (w_cur)
	);

	sha256_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.w_cur    (w_cur),
		.rd_index (cnt_q[2:0]),
		.rd_word  (rd_word)
	);

endmodule
